@@ hdl/quorum_representative_select_unit_defines.svh @@
`ifndef QUORUM_REPRESENTATIVE_SELECT_UNIT_DEFINES_SVH
`define QUORUM_REPRESENTATIVE_SELECT_UNIT_DEFINES_SVH

// same-cycle implication, checked at every rising edge outside reset
`define QRS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define QRS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/qrs_pkg.sv @@
package qrs_pkg;

  localparam int unsigned MAX_NODES   = 32;
  localparam int unsigned STATE_W     = 3;
  localparam int unsigned UUID_W      = 64;
  localparam int unsigned SEQ_W       = 64;
  localparam int unsigned PROTO_W     = 7;
  localparam int unsigned PROTO_OUT_W = 8;
  localparam int unsigned PADDR_W     = 3;
  localparam int unsigned PDATA_W     = 32;

  localparam logic [STATE_W-1:0]   ELIG_MIN_RESET   = 3'd3;
  localparam logic [PADDR_W-3:0]   REG_IDX_ELIG_MIN = 1'b0;

  typedef enum logic [1:0] {
    OUTCOME_PRIMARY  = 2'd0,
    OUTCOME_NO_NODE  = 2'd1,
    OUTCOME_CONFLICT = 2'd2,
    OUTCOME_OVERFLOW = 2'd3
  } outcome_e;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_DECIDE,
    ST_WALK,
    ST_TAIL,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic accept;
    logic walk_init;
    logic walk_rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic primary;
    logic walk_last;
    logic out_free;
  } sts_t;

endpackage

@@ hdl/qrs_ctrl.sv @@
module qrs_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_last_i,
  output logic            in_ready_o,
  output qrs_pkg::cmd_t   cmd_o,
  input  qrs_pkg::sts_t   sts_i
);

  qrs_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      qrs_pkg::ST_LOAD: begin
        if (in_valid_i && in_last_i) state_d = qrs_pkg::ST_DECIDE;
      end
      qrs_pkg::ST_DECIDE: begin
        state_d = sts_i.primary ? qrs_pkg::ST_WALK : qrs_pkg::ST_DONE;
      end
      qrs_pkg::ST_WALK: begin
        if (sts_i.walk_last) state_d = qrs_pkg::ST_TAIL;
      end
      qrs_pkg::ST_TAIL: begin
        state_d = qrs_pkg::ST_DONE;
      end
      qrs_pkg::ST_DONE: begin
        if (sts_i.out_free) state_d = qrs_pkg::ST_LOAD;
      end
      default: begin
        state_d = qrs_pkg::ST_LOAD;
      end
    endcase
  end

  always_comb begin
    in_ready_o      = (state_q == qrs_pkg::ST_LOAD);
    cmd_o.accept    = (state_q == qrs_pkg::ST_LOAD) && in_valid_i;
    cmd_o.walk_init = (state_q == qrs_pkg::ST_DECIDE) && sts_i.primary;
    cmd_o.walk_rd   = (state_q == qrs_pkg::ST_WALK);
    cmd_o.finish    = (state_q == qrs_pkg::ST_DONE) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qrs_pkg::ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ hdl/qrs_dp.sv @@
`include "quorum_representative_select_unit_defines.svh"

module qrs_dp #(
  parameter int unsigned MaxNodes = qrs_pkg::MAX_NODES
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  qrs_pkg::cmd_t                           cmd_i,
  output qrs_pkg::sts_t                           sts_o,
  input  logic [qrs_pkg::STATE_W-1:0]             elig_min_i,
  input  logic [qrs_pkg::STATE_W-1:0]             node_state_i,
  input  logic [qrs_pkg::UUID_W-1:0]              uuid_high_i,
  input  logic [qrs_pkg::UUID_W-1:0]              uuid_low_i,
  input  logic signed [qrs_pkg::SEQ_W-1:0]        act_i,
  input  logic signed [qrs_pkg::SEQ_W-1:0]        conf_i,
  input  logic [qrs_pkg::PROTO_W-1:0]             proto_low_i,
  input  logic [qrs_pkg::PROTO_W-1:0]             proto_high_i,
  input  logic                                    out_ready_i,
  output logic                                    out_valid_o,
  output logic [1:0]                              outcome_o,
  output logic                                    primary_o,
  output logic [qrs_pkg::UUID_W-1:0]              quorum_uuid_high_o,
  output logic [qrs_pkg::UUID_W-1:0]              quorum_uuid_low_o,
  output logic signed [qrs_pkg::SEQ_W-1:0]        act_id_o,
  output logic signed [qrs_pkg::SEQ_W-1:0]        conf_id_o,
  output logic signed [qrs_pkg::PROTO_OUT_W-1:0]  proto_o
);

  localparam int unsigned AW = $clog2(MaxNodes);
  localparam int unsigned CW = $clog2(MaxNodes + 1);

  // set state
  logic [CW-1:0] count_q, count_d;
  logic          found_q, found_d;
  logic          conflict_q, conflict_d;
  logic          ovf_q, ovf_d;
  logic [qrs_pkg::UUID_W-1:0]       rep_uh_q, rep_uh_d, rep_ul_q, rep_ul_d;
  logic signed [qrs_pkg::SEQ_W-1:0] rep_act_q, rep_act_d, rep_conf_q, rep_conf_d;
  logic [qrs_pkg::PROTO_W-1:0]      rep_plo_q, rep_plo_d, rep_phi_q, rep_phi_d;

  // protocol walk
  logic [qrs_pkg::PROTO_W-1:0] proto_mem_q [MaxNodes];
  logic [qrs_pkg::PROTO_W-1:0] rd_data_q;
  logic [AW-1:0]               rd_addr_q, rd_addr_d;
  logic                        rd_vld_q, rd_vld_d;
  logic [qrs_pkg::PROTO_W-1:0] best_q, best_d;
  logic                        wr_en;

  // output word
  logic                                   out_valid_q, out_valid_d;
  qrs_pkg::outcome_e                      outcome_q, outcome_d, outcome_cur;
  logic                                   primary_q, primary_d;
  logic [qrs_pkg::UUID_W-1:0]             o_uh_q, o_uh_d, o_ul_q, o_ul_d;
  logic signed [qrs_pkg::SEQ_W-1:0]       o_act_q, o_act_d, o_conf_q, o_conf_d;
  logic signed [qrs_pkg::PROTO_OUT_W-1:0] o_proto_q, o_proto_d;

  logic full, eligible, better, same_uuid, out_free;

  assign full      = (count_q == CW'(MaxNodes));
  assign eligible  = (node_state_i >= elig_min_i);
  assign same_uuid = (uuid_high_i == rep_uh_q) && (uuid_low_i == rep_ul_q);
  assign better    = (rep_act_q < act_i) || ((rep_act_q == act_i) && (rep_conf_q < conf_i));
  assign out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    if (ovf_q) outcome_cur = qrs_pkg::OUTCOME_OVERFLOW;
    else if (!found_q) outcome_cur = qrs_pkg::OUTCOME_NO_NODE;
    else if (conflict_q) outcome_cur = qrs_pkg::OUTCOME_CONFLICT;
    else outcome_cur = qrs_pkg::OUTCOME_PRIMARY;
  end

  assign sts_o.primary   = (outcome_cur == qrs_pkg::OUTCOME_PRIMARY);
  assign sts_o.walk_last = (CW'(rd_addr_q) == count_q - CW'(1));
  assign sts_o.out_free  = out_free;

  always_comb begin
    count_d    = count_q;
    found_d    = found_q;
    conflict_d = conflict_q;
    ovf_d      = ovf_q;
    rep_uh_d   = rep_uh_q;
    rep_ul_d   = rep_ul_q;
    rep_act_d  = rep_act_q;
    rep_conf_d = rep_conf_q;
    rep_plo_d  = rep_plo_q;
    rep_phi_d  = rep_phi_q;
    wr_en      = 1'b0;
    if (cmd_i.accept) begin
      if (full) begin
        ovf_d = 1'b1;
      end else begin
        wr_en   = 1'b1;
        count_d = count_q + CW'(1);
        if (eligible) begin
          if (!found_q) begin
            found_d    = 1'b1;
            rep_uh_d   = uuid_high_i;
            rep_ul_d   = uuid_low_i;
            rep_act_d  = act_i;
            rep_conf_d = conf_i;
            rep_plo_d  = proto_low_i;
            rep_phi_d  = proto_high_i;
          end else if (!conflict_q) begin
            if (!same_uuid) begin
              conflict_d = 1'b1;
            end else if (better) begin
              rep_act_d  = act_i;
              rep_conf_d = conf_i;
              rep_plo_d  = proto_low_i;
              rep_phi_d  = proto_high_i;
            end
          end
        end
      end
    end
    if (cmd_i.finish) begin
      count_d    = '0;
      found_d    = 1'b0;
      conflict_d = 1'b0;
      ovf_d      = 1'b0;
    end
  end

  always_comb begin
    rd_addr_d = rd_addr_q;
    rd_vld_d  = cmd_i.walk_rd;
    best_d    = best_q;
    if (cmd_i.walk_init) begin
      rd_addr_d = '0;
      best_d    = rep_phi_q;
    end else if (cmd_i.walk_rd) begin
      rd_addr_d = rd_addr_q + AW'(1);
    end
    // keep the smallest stored maximum in [rep low, current best)
    if (rd_vld_q && (rd_data_q < best_q) && (rd_data_q >= rep_plo_q)) begin
      best_d = rd_data_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    outcome_d   = outcome_q;
    primary_d   = primary_q;
    o_uh_d      = o_uh_q;
    o_ul_d      = o_ul_q;
    o_act_d     = o_act_q;
    o_conf_d    = o_conf_q;
    o_proto_d   = o_proto_q;
    if (cmd_i.finish) begin
      out_valid_d = 1'b1;
      outcome_d   = outcome_cur;
      if (outcome_cur == qrs_pkg::OUTCOME_PRIMARY) begin
        primary_d = 1'b1;
        o_uh_d    = rep_uh_q;
        o_ul_d    = rep_ul_q;
        o_act_d   = rep_act_q;
        o_conf_d  = rep_conf_q;
        o_proto_d = {1'b0, best_q};
      end else begin
        primary_d = 1'b0;
        o_uh_d    = '0;
        o_ul_d    = '0;
        o_act_d   = '1;
        o_conf_d  = '1;
        o_proto_d = '1;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      found_q     <= 1'b0;
      conflict_q  <= 1'b0;
      ovf_q       <= 1'b0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      found_q     <= found_d;
      conflict_q  <= conflict_d;
      ovf_q       <= ovf_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rep_uh_q   <= rep_uh_d;
    rep_ul_q   <= rep_ul_d;
    rep_act_q  <= rep_act_d;
    rep_conf_q <= rep_conf_d;
    rep_plo_q  <= rep_plo_d;
    rep_phi_q  <= rep_phi_d;
    rd_addr_q  <= rd_addr_d;
    best_q     <= best_d;
    outcome_q  <= outcome_d;
    primary_q  <= primary_d;
    o_uh_q     <= o_uh_d;
    o_ul_q     <= o_ul_d;
    o_act_q    <= o_act_d;
    o_conf_q   <= o_conf_d;
    o_proto_q  <= o_proto_d;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) proto_mem_q[count_q[AW-1:0]] <= proto_high_i;
    if (cmd_i.walk_rd) rd_data_q <= proto_mem_q[rd_addr_q];
  end

  assign out_valid_o        = out_valid_q;
  assign outcome_o          = outcome_q;
  assign primary_o          = primary_q;
  assign quorum_uuid_high_o = o_uh_q;
  assign quorum_uuid_low_o  = o_ul_q;
  assign act_id_o           = o_act_q;
  assign conf_id_o          = o_conf_q;
  assign proto_o            = o_proto_q;

  `QRS_ASSERT_NOW(a_count_range, clk_i, rst_ni, 1'b1, count_q <= CW'(MaxNodes), "node count past limit")
  `QRS_ASSERT_NOW(a_conflict_needs_rep, clk_i, rst_ni, conflict_q, found_q, "conflict without representative")
  `QRS_ASSERT_NOW(a_walk_only_primary, clk_i, rst_ni, cmd_i.walk_rd, sts_o.primary && (count_q != '0), "walk outside primary set")
  `QRS_ASSERT_NEXT(a_finish_clears, clk_i, rst_ni, cmd_i.finish, out_valid_q && (count_q == '0) && !found_q && !ovf_q, "set state not cleared after decision")

endmodule

@@ hdl/quorum_representative_select_unit.sv @@
// quorum representative select unit
// input channel: one node record per word (in_valid_i / in_ready_o), last_node_i marks
// the final record of a set; one record is taken per cycle while a set is loading.
// output channel: one decision word per set (out_valid_o / out_ready_i).
// config: apb-style port, eligible_state_min at byte address 0, pready always high.
// after the last word is accepted the controller passes through these states:
//   not primary: DECIDE, then DONE, where the decision word is registered
//   primary: DECIDE, WALK over the N records held in the set, TAIL, then DONE; the walk reads
//   the protocol memory through its single read port, one entry per cycle
// a set of N records is loaded one record at a time before these states;
// in_ready_o stays low from the last word until the decision word is registered.
// the decision sits in an output register, so the next set loads while it waits.
// a stalled receiver holds the decision word; a new decision waits until the
// previous one is taken.
// reset: no set in progress, no decision pending, eligible_state_min = 3; the
// protocol memory is not cleared, only entries of the current set are read.
module quorum_representative_select_unit #(
  parameter int unsigned MaxNodes = qrs_pkg::MAX_NODES
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    psel,
  input  logic                                    penable,
  input  logic                                    pwrite,
  input  logic [qrs_pkg::PADDR_W-1:0]             paddr,
  input  logic [qrs_pkg::PDATA_W-1:0]             pwdata,
  output logic [qrs_pkg::PDATA_W-1:0]             prdata,
  output logic                                    pready,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [qrs_pkg::STATE_W-1:0]             node_state_i,
  input  logic [qrs_pkg::UUID_W-1:0]              group_uuid_high_i,
  input  logic [qrs_pkg::UUID_W-1:0]              group_uuid_low_i,
  input  logic signed [qrs_pkg::SEQ_W-1:0]        act_seqno_i,
  input  logic signed [qrs_pkg::SEQ_W-1:0]        conf_seqno_i,
  input  logic [qrs_pkg::PROTO_W-1:0]             proto_low_i,
  input  logic [qrs_pkg::PROTO_W-1:0]             proto_high_i,
  input  logic                                    last_node_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [1:0]                              outcome_o,
  output logic                                    primary_o,
  output logic [qrs_pkg::UUID_W-1:0]              quorum_uuid_high_o,
  output logic [qrs_pkg::UUID_W-1:0]              quorum_uuid_low_o,
  output logic signed [qrs_pkg::SEQ_W-1:0]        act_id_o,
  output logic signed [qrs_pkg::SEQ_W-1:0]        conf_id_o,
  output logic signed [qrs_pkg::PROTO_OUT_W-1:0]  proto_o
);

  logic [qrs_pkg::STATE_W-1:0] elig_min_q, elig_min_d;
  logic                        reg_hit;
  qrs_pkg::cmd_t               cmd;
  qrs_pkg::sts_t               sts;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[qrs_pkg::PADDR_W-1:2] == qrs_pkg::REG_IDX_ELIG_MIN);
  assign prdata  = reg_hit ? qrs_pkg::PDATA_W'(elig_min_q) : '0;

  always_comb begin
    elig_min_d = elig_min_q;
    if (psel && penable && pwrite && reg_hit) begin
      elig_min_d = pwdata[qrs_pkg::STATE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elig_min_q <= qrs_pkg::ELIG_MIN_RESET;
    end else begin
      elig_min_q <= elig_min_d;
    end
  end

  qrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (last_node_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  qrs_dp #(
    .MaxNodes (MaxNodes)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .sts_o              (sts),
    .elig_min_i         (elig_min_q),
    .node_state_i       (node_state_i),
    .uuid_high_i        (group_uuid_high_i),
    .uuid_low_i         (group_uuid_low_i),
    .act_i              (act_seqno_i),
    .conf_i             (conf_seqno_i),
    .proto_low_i        (proto_low_i),
    .proto_high_i       (proto_high_i),
    .out_ready_i        (out_ready_i),
    .out_valid_o        (out_valid_o),
    .outcome_o          (outcome_o),
    .primary_o          (primary_o),
    .quorum_uuid_high_o (quorum_uuid_high_o),
    .quorum_uuid_low_o  (quorum_uuid_low_o),
    .act_id_o           (act_id_o),
    .conf_id_o          (conf_id_o),
    .proto_o            (proto_o)
  );

endmodule
